// ----- design/cafp_pkg.sv -----
// Shared types, codes and constants for the cell artwork file parser.
`default_nettype none

package cafp_pkg;

    typedef enum logic [4:0] {
        PH_SIG0      = 5'd0,
        PH_SIG1      = 5'd1,
        PH_SIG2      = 5'd2,
        PH_SIG3      = 5'd3,
        PH_SIG4      = 5'd4,
        PH_SIG5      = 5'd5,
        PH_REV_LO    = 5'd6,
        PH_REV_HI    = 5'd7,
        PH_NAME_LEN  = 5'd8,
        PH_NAME_CH   = 5'd9,
        PH_WIDTH     = 5'd10,
        PH_HEIGHT    = 5'd11,
        PH_CS_LEN    = 5'd12,
        PH_CS_CH     = 5'd13,
        PH_PAL_LEN   = 5'd14,
        PH_PAL_CH    = 5'd15,
        PH_LCOUNT    = 5'd16,
        PH_LNAME_LEN = 5'd17,
        PH_LNAME_CH  = 5'd18,
        PH_DEPTH     = 5'd19,
        PH_ALPHA     = 5'd20,
        PH_LFLAGS    = 5'd21,
        PH_GLYPH_LO  = 5'd22,
        PH_GLYPH_HI  = 5'd23,
        PH_FORE      = 5'd24,
        PH_BACK      = 5'd25,
        PH_CFLAGS    = 5'd26,
        PH_IDLE      = 5'd27
    } t_phase;

    localparam logic [2:0] REC_NAME_CHAR    = 3'd0;
    localparam logic [2:0] REC_HEADER       = 3'd1;
    localparam logic [2:0] REC_LAYER_HEADER = 3'd2;
    localparam logic [2:0] REC_CELL         = 3'd3;
    localparam logic [2:0] REC_BAD_SIG      = 3'd4;
    localparam logic [2:0] REC_BAD_REV      = 3'd5;

    localparam logic [1:0] SRC_ART     = 2'd0;
    localparam logic [1:0] SRC_CHARSET = 2'd1;
    localparam logic [1:0] SRC_PALETTE = 2'd2;
    localparam logic [1:0] SRC_LAYER   = 2'd3;

    localparam logic [31:0] REVISION      = 32'd4;
    localparam logic [7:0]  FLOAT_BYTES   = 8'd4;
    localparam logic [7:0]  LAYER_VISIBLE = 8'h01;
    localparam logic [7:0]  CELL_FLAGS    = 8'h0F;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [1:0]  name_source;
        logic [7:0]  name_char;
        logic [7:0]  layer_index;
        logic [15:0] cell_index;
        logic [15:0] glyph_value;
        logic [7:0]  fore_or_width;
        logic [7:0]  back_or_height;
        logic [3:0]  flag_bits;
        logic [31:0] depth_offset_bits;
        logic [31:0] alpha_bits;
        logic        end_of_file;
    } t_record;

    function automatic logic [7:0] f_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h33;
            3'd1:    v = 8'h44;
            3'd2:    v = 8'h53;
            3'd3:    v = 8'h43;
            default: v = 8'h49;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/cafp_core.sv -----
// Parse state registers and the per-word phase and record logic.
`default_nettype none

module cafp_core
    import cafp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic    i_frame_start,
    output logic         o_res_valid,
    output t_record      o_rec
);

    t_phase      r_phase, n_phase, e_phase;
    logic [7:0]  r_bytes_left, n_bytes_left, e_bytes_left;
    logic [7:0]  r_width, n_width, e_width;
    logic [7:0]  r_height, n_height, e_height;
    logic [7:0]  r_layers_total, n_layers_total, e_layers_total;
    logic [7:0]  r_layer, n_layer, e_layer;
    logic [15:0] r_cell, n_cell, e_cell;
    logic [15:0] r_cpl, n_cpl, e_cpl;
    logic [31:0] r_gather, n_gather, e_gather;
    logic [31:0] r_depth, n_depth, e_depth;
    logic [15:0] r_glyph, n_glyph, e_glyph;
    logic [7:0]  r_fore, n_fore, e_fore;
    logic [7:0]  r_back, n_back, e_back;

    logic [7:0]  w_b;
    logic [7:0]  w_left_dec;
    logic [7:0]  w_layer_inc;
    logic        w_last_layer;
    logic [15:0] w_cell_inc;
    logic [31:0] w_gather_shift;

    assign w_b = i_data_byte;

    always_comb begin
        if (i_frame_start) begin
            e_phase        = PH_SIG0;
            e_bytes_left   = '0;
            e_width        = '0;
            e_height       = '0;
            e_layers_total = '0;
            e_layer        = '0;
            e_cell         = '0;
            e_cpl          = '0;
            e_gather       = '0;
            e_depth        = '0;
            e_glyph        = '0;
            e_fore         = '0;
            e_back         = '0;
        end else begin
            e_phase        = r_phase;
            e_bytes_left   = r_bytes_left;
            e_width        = r_width;
            e_height       = r_height;
            e_layers_total = r_layers_total;
            e_layer        = r_layer;
            e_cell         = r_cell;
            e_cpl          = r_cpl;
            e_gather       = r_gather;
            e_depth        = r_depth;
            e_glyph        = r_glyph;
            e_fore         = r_fore;
            e_back         = r_back;
        end
    end

    assign w_left_dec     = e_bytes_left - 8'd1;
    assign w_layer_inc    = e_layer + 8'd1;
    assign w_last_layer   = (w_layer_inc == e_layers_total);
    assign w_cell_inc     = e_cell + 16'd1;
    assign w_gather_shift = {w_b, e_gather[31:8]};

    // next state
    always_comb begin
        n_phase        = e_phase;
        n_bytes_left   = e_bytes_left;
        n_width        = e_width;
        n_height       = e_height;
        n_layers_total = e_layers_total;
        n_layer        = e_layer;
        n_cell         = e_cell;
        n_cpl          = e_cpl;
        n_gather       = e_gather;
        n_depth        = e_depth;
        n_glyph        = e_glyph;
        n_fore         = e_fore;
        n_back         = e_back;
        case (e_phase)
            PH_SIG0, PH_SIG1, PH_SIG2, PH_SIG3, PH_SIG4, PH_SIG5: begin
                if (w_b != f_sig_byte(e_phase[2:0])) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = t_phase'(e_phase + 5'd1);
                end
            end
            PH_REV_LO: begin
                n_gather = {24'd0, w_b};
                n_phase  = PH_REV_HI;
            end
            PH_REV_HI: begin
                if ((e_gather | {16'd0, w_b, 8'd0}) != REVISION) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_NAME_LEN;
                end
            end
            PH_NAME_LEN: begin
                n_bytes_left = (w_b == 8'd0) ? e_bytes_left : w_b;
                n_phase      = (w_b == 8'd0) ? PH_WIDTH : PH_NAME_CH;
            end
            PH_NAME_CH: begin
                n_bytes_left = w_left_dec;
                if (w_left_dec == 8'd0) n_phase = PH_WIDTH;
            end
            PH_WIDTH: begin
                n_width = w_b;
                n_phase = PH_HEIGHT;
            end
            PH_HEIGHT: begin
                n_height = w_b;
                n_cpl    = {8'd0, e_width} * {8'd0, w_b};
                n_phase  = PH_CS_LEN;
            end
            PH_CS_LEN: begin
                n_bytes_left = (w_b == 8'd0) ? e_bytes_left : w_b;
                n_phase      = (w_b == 8'd0) ? PH_PAL_LEN : PH_CS_CH;
            end
            PH_CS_CH: begin
                n_bytes_left = w_left_dec;
                if (w_left_dec == 8'd0) n_phase = PH_PAL_LEN;
            end
            PH_PAL_LEN: begin
                n_bytes_left = (w_b == 8'd0) ? e_bytes_left : w_b;
                n_phase      = (w_b == 8'd0) ? PH_LCOUNT : PH_PAL_CH;
            end
            PH_PAL_CH: begin
                n_bytes_left = w_left_dec;
                if (w_left_dec == 8'd0) n_phase = PH_LCOUNT;
            end
            PH_LCOUNT: begin
                n_layers_total = w_b;
                n_layer        = '0;
                n_cell         = '0;
                n_phase        = (w_b == 8'd0) ? PH_IDLE : PH_LNAME_LEN;
            end
            PH_LNAME_LEN: begin
                if (w_b == 8'd0) begin
                    n_bytes_left = FLOAT_BYTES;
                    n_phase      = PH_DEPTH;
                end else begin
                    n_bytes_left = w_b;
                    n_phase      = PH_LNAME_CH;
                end
            end
            PH_LNAME_CH: begin
                if (w_left_dec == 8'd0) begin
                    n_bytes_left = FLOAT_BYTES;
                    n_phase      = PH_DEPTH;
                end else begin
                    n_bytes_left = w_left_dec;
                end
            end
            PH_DEPTH: begin
                n_gather     = w_gather_shift;
                n_bytes_left = w_left_dec;
                if (w_left_dec == 8'd0) begin
                    n_depth      = w_gather_shift;
                    n_bytes_left = FLOAT_BYTES;
                    n_phase      = PH_ALPHA;
                end
            end
            PH_ALPHA: begin
                n_gather     = w_gather_shift;
                n_bytes_left = w_left_dec;
                if (w_left_dec == 8'd0) n_phase = PH_LFLAGS;
            end
            PH_LFLAGS: begin
                n_cell = '0;
                if (e_cpl == 16'd0) begin
                    n_layer = w_layer_inc;
                    n_phase = w_last_layer ? PH_IDLE : PH_LNAME_LEN;
                end else begin
                    n_phase = PH_GLYPH_LO;
                end
            end
            PH_GLYPH_LO: begin
                n_glyph = {8'd0, w_b};
                n_phase = PH_GLYPH_HI;
            end
            PH_GLYPH_HI: begin
                n_glyph = {w_b, e_glyph[7:0]} | e_glyph;
                n_phase = PH_FORE;
            end
            PH_FORE: begin
                n_fore  = w_b;
                n_phase = PH_BACK;
            end
            PH_BACK: begin
                n_back  = w_b;
                n_phase = PH_CFLAGS;
            end
            PH_CFLAGS: begin
                if (w_cell_inc == e_cpl) begin
                    n_cell  = '0;
                    n_layer = w_layer_inc;
                    n_phase = w_last_layer ? PH_IDLE : PH_LNAME_LEN;
                end else begin
                    n_cell  = w_cell_inc;
                    n_phase = PH_GLYPH_LO;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // record
    always_comb begin
        o_res_valid = 1'b0;
        o_rec       = '0;
        case (e_phase)
            PH_SIG0, PH_SIG1, PH_SIG2, PH_SIG3, PH_SIG4, PH_SIG5: begin
                if (w_b != f_sig_byte(e_phase[2:0])) begin
                    o_res_valid       = 1'b1;
                    o_rec.record_kind = REC_BAD_SIG;
                end
            end
            PH_REV_HI: begin
                if ((e_gather | {16'd0, w_b, 8'd0}) != REVISION) begin
                    o_res_valid       = 1'b1;
                    o_rec.record_kind = REC_BAD_REV;
                end
            end
            PH_NAME_CH, PH_CS_CH, PH_PAL_CH, PH_LNAME_CH: begin
                o_res_valid       = 1'b1;
                o_rec.record_kind = REC_NAME_CHAR;
                o_rec.name_char   = w_b;
                case (e_phase)
                    PH_NAME_CH: o_rec.name_source = SRC_ART;
                    PH_CS_CH:   o_rec.name_source = SRC_CHARSET;
                    PH_PAL_CH:  o_rec.name_source = SRC_PALETTE;
                    default: begin
                        o_rec.name_source = SRC_LAYER;
                        o_rec.layer_index = e_layer;
                    end
                endcase
            end
            PH_LCOUNT: begin
                o_res_valid          = 1'b1;
                o_rec.record_kind    = REC_HEADER;
                o_rec.layer_index    = w_b;
                o_rec.fore_or_width  = e_width;
                o_rec.back_or_height = e_height;
                o_rec.end_of_file    = (w_b == 8'd0);
            end
            PH_LFLAGS: begin
                o_res_valid             = 1'b1;
                o_rec.record_kind       = REC_LAYER_HEADER;
                o_rec.layer_index       = e_layer;
                o_rec.flag_bits         = 4'(w_b & LAYER_VISIBLE);
                o_rec.depth_offset_bits = e_depth;
                o_rec.alpha_bits        = e_gather;
                o_rec.end_of_file       = (e_cpl == 16'd0) && w_last_layer;
            end
            PH_CFLAGS: begin
                o_res_valid          = 1'b1;
                o_rec.record_kind    = REC_CELL;
                o_rec.layer_index    = e_layer;
                o_rec.cell_index     = e_cell;
                o_rec.glyph_value    = e_glyph;
                o_rec.fore_or_width  = e_fore;
                o_rec.back_or_height = e_back;
                o_rec.flag_bits      = 4'(w_b & CELL_FLAGS);
                o_rec.end_of_file    = (w_cell_inc == e_cpl) && w_last_layer;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIG0;
            r_bytes_left   <= '0;
            r_width        <= '0;
            r_height       <= '0;
            r_layers_total <= '0;
            r_layer        <= '0;
            r_cell         <= '0;
            r_cpl          <= '0;
            r_gather       <= '0;
            r_depth        <= '0;
            r_glyph        <= '0;
            r_fore         <= '0;
            r_back         <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_bytes_left   <= n_bytes_left;
            r_width        <= n_width;
            r_height       <= n_height;
            r_layers_total <= n_layers_total;
            r_layer        <= n_layer;
            r_cell         <= n_cell;
            r_cpl          <= n_cpl;
            r_gather       <= n_gather;
            r_depth        <= n_depth;
            r_glyph        <= n_glyph;
            r_fore         <= n_fore;
            r_back         <= n_back;
        end
    end

endmodule

`default_nettype wire

// ----- design/cafp_out_buf.sv -----
// Result register with one skid entry between the parser and the output channel.
`default_nettype none

module cafp_out_buf
    import cafp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_record i_rec,
    output logic         o_can_push,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_record      o_rec
);

    logic    r_out_valid, r_skid_valid;
    t_record r_out, r_skid;
    logic    w_pop;

    assign w_pop      = r_out_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_rec      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push) begin
                if (!r_out_valid || w_pop) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_valid  <= r_skid_valid;
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= i_rec;
            end else begin
                r_skid <= i_rec;
            end
        end else if (w_pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

`default_nettype wire

// ----- design/cell_art_file_parser.sv -----
// Top level of the byte-serial cell artwork file parser.
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_ready    i_data_byte, i_frame_start
//  output   out        o_out_valid / i_out_ready  o_record_kind .. o_end_of_file
//
// One word per cycle while not stalled: each byte updates the parse phase and
// yields at most one record, held in a register. A result register plus one
// skid entry keeps input flowing while a record waits; input stalls only when
// both hold. Synchronous active-low reset expects the first signature byte; a
// word with i_frame_start restarts the parse from that word.
`default_nettype none

module cell_art_file_parser
    import cafp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_record_kind,
    output logic [1:0]       o_name_source,
    output logic [7:0]       o_name_char,
    output logic [7:0]       o_layer_index,
    output logic [15:0]      o_cell_index,
    output logic [15:0]      o_glyph_value,
    output logic [7:0]       o_fore_or_width,
    output logic [7:0]       o_back_or_height,
    output logic [3:0]       o_flag_bits,
    output logic [31:0]      o_depth_offset_bits,
    output logic [31:0]      o_alpha_bits,
    output logic             o_end_of_file
);

    logic    w_accept;
    logic    w_res_valid;
    t_record w_rec;
    t_record w_out_rec;

    assign w_accept = i_in_valid && o_in_ready;

    cafp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_res_valid   (w_res_valid),
        .o_rec         (w_rec)
    );

    cafp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept && w_res_valid),
        .i_rec      (w_rec),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_rec      (w_out_rec)
    );

    assign o_record_kind       = w_out_rec.record_kind;
    assign o_name_source       = w_out_rec.name_source;
    assign o_name_char         = w_out_rec.name_char;
    assign o_layer_index       = w_out_rec.layer_index;
    assign o_cell_index        = w_out_rec.cell_index;
    assign o_glyph_value       = w_out_rec.glyph_value;
    assign o_fore_or_width     = w_out_rec.fore_or_width;
    assign o_back_or_height    = w_out_rec.back_or_height;
    assign o_flag_bits         = w_out_rec.flag_bits;
    assign o_depth_offset_bits = w_out_rec.depth_offset_bits;
    assign o_alpha_bits        = w_out_rec.alpha_bits;
    assign o_end_of_file       = w_out_rec.end_of_file;

endmodule

`default_nettype wire
